/* rtl/core/pfsa_pkg.sv */
// pfsa_pkg: shared types and codes of the page free stack allocator.
// Controller/datapath command and status structs, status and opcode codes.
// No dependencies.
package pfsa_pkg;

	localparam int LEN_W  = 32;
	localparam int ADDR_W = 32;
	localparam int STAT_W = 3;

	// configuration register indexes
	localparam logic REG_REGION_BASE = 1'b0;
	localparam logic REG_PAGE_COUNT  = 1'b1;

	// request kinds
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_BAD_LEN     = 3'd1,
		STAT_NO_PAGES    = 3'd2,
		STAT_FREE_IGNORE = 3'd3,
		STAT_STACK_FULL  = 3'd4
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;        // request beat accepted this cycle
		logic finish_pop;  // stack read data valid, load result
	} pfsa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;    // result register empty or being drained
		logic will_pop;    // pending request is served from the stack
	} pfsa_stat_t;

endpackage

/* rtl/core/pfsa_ctrl.sv */
// pfsa_ctrl: request sequencer of the page free stack allocator.
// Depends on pfsa_pkg (state_t, pfsa_cmd_t, pfsa_stat_t).
module pfsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  pfsa_pkg::pfsa_stat_t stat,
	output pfsa_pkg::pfsa_cmd_t  cmd
);

	pfsa_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfsa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx       = state_q;
		s_tready       = 1'b0;
		cmd.take       = 1'b0;
		cmd.finish_pop = 1'b0;
		case (state_q)
			pfsa_pkg::ST_IDLE: begin
				s_tready = stat.out_free;
				cmd.take = s_tvalid && stat.out_free;
				if (cmd.take && stat.will_pop) begin
					state_nx = pfsa_pkg::ST_POP;
				end
			end
			pfsa_pkg::ST_POP: begin
				// stack entry is in the read register now
				cmd.finish_pop = 1'b1;
				state_nx       = pfsa_pkg::ST_IDLE;
			end
			default: begin
				state_nx = pfsa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/pfsa_datapath.sv */
// pfsa_datapath: region registers, free page stack memory, linear cursor
// and result register of the page free stack allocator.
// Depends on pfsa_pkg (codes, pfsa_cmd_t, pfsa_stat_t).
module pfsa_datapath #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic                 s_tuser,
	input  logic [63:0]          s_tdata,
	input  logic                 m_tready,
	input  pfsa_pkg::pfsa_cmd_t  cmd,
	output pfsa_pkg::pfsa_stat_t stat,
	output logic                 m_tvalid,
	output logic [39:0]          m_tdata
);

	localparam int PS    = $clog2(PAGE_BYTES);
	localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int CNT_W = $clog2(MAX_PAGES + 1);
	localparam int XW    = 33;

	logic [31:0]      base_q;
	logic [15:0]      count_q;
	logic [CNT_W-1:0] stack_cnt_q;
	logic [CNT_W-1:0] cursor_q;
	logic             exh_q;
	logic [IDX_W-1:0] rd_q;
	logic             out_valid_q;
	logic [31:0]      out_addr_q;
	pfsa_pkg::status_t out_stat_q;

	logic [IDX_W-1:0] mem [MAX_PAGES];

	logic [31:0]      req_len, free_addr, abase;
	logic [XW-1:0]    room, lim, off, idx_x;
	logic [CNT_W-1:0] pages, cursor_nx;
	logic             len_ok, stack_nz, stack_full, in_region, owned;
	logic             do_pop, do_push;

	assign req_len   = s_tdata[31:0];
	assign free_addr = s_tdata[63:32];
	assign abase     = {base_q[31:PS], {PS{1'b0}}};

	// usable pages: count limited to MAX_PAGES and to the room below 2^32
	always_comb begin
		room = (XW'(1) << (32 - PS)) - XW'(base_q[31:PS]);
		lim  = XW'(count_q);
		if (lim > XW'(MAX_PAGES)) begin
			lim = XW'(MAX_PAGES);
		end
		if (lim > room) begin
			lim = room;
		end
	end
	assign pages = lim[CNT_W-1:0];

	assign len_ok     = (req_len[PS-1:0] == '0);
	assign stack_nz   = (stack_cnt_q != '0);
	assign stack_full = (stack_cnt_q == CNT_W'(MAX_PAGES));
	assign cursor_nx  = cursor_q + CNT_W'(1);

	assign in_region = (free_addr >= abase);
	assign off       = XW'(free_addr - abase);
	assign idx_x     = off >> PS;
	assign owned     = in_region && (off[PS-1:0] == '0) && (idx_x < XW'(pages));

	assign do_pop  = cmd.take && (s_tuser == pfsa_pkg::OP_ALLOC) && len_ok && stack_nz;
	assign do_push = cmd.take && (s_tuser == pfsa_pkg::OP_FREE) && owned && !stack_full;

	assign stat.out_free = !out_valid_q || m_tready;
	assign stat.will_pop = (s_tuser == pfsa_pkg::OP_ALLOC) && len_ok && stack_nz;

	// stack memory, registered read
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[stack_cnt_q[IDX_W-1:0]] <= idx_x[IDX_W-1:0];
		end
		if (do_pop) begin
			rd_q <= mem[stack_cnt_q[IDX_W-1:0] - IDX_W'(1)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= 32'd4096;
			count_q     <= 16'd16;
			stack_cnt_q <= '0;
			cursor_q    <= '0;
			exh_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			// any write restarts the allocator
			if (cfg_index == pfsa_pkg::REG_REGION_BASE) begin
				base_q <= cfg_wdata;
			end else begin
				count_q <= cfg_wdata[15:0];
			end
			stack_cnt_q <= '0;
			cursor_q    <= '0;
			exh_q       <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.finish_pop) begin
				out_valid_q <= 1'b1;
				out_addr_q  <= abase + (32'(rd_q) << PS);
				out_stat_q  <= pfsa_pkg::STAT_OK;
			end else if (cmd.take) begin
				out_addr_q <= '0;
				if (s_tuser == pfsa_pkg::OP_ALLOC) begin
					if (!len_ok) begin
						out_valid_q <= 1'b1;
						out_stat_q  <= pfsa_pkg::STAT_BAD_LEN;
					end else if (stack_nz) begin
						// result comes from the stack read, loaded in the pop state
						stack_cnt_q <= stack_cnt_q - CNT_W'(1);
					end else if (!exh_q && (cursor_q < pages)) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= abase + (32'(cursor_q) << PS);
						out_stat_q  <= pfsa_pkg::STAT_OK;
						cursor_q    <= cursor_nx;
						if (cursor_nx >= pages) begin
							exh_q <= 1'b1;
						end
					end else begin
						out_valid_q <= 1'b1;
						out_stat_q  <= pfsa_pkg::STAT_NO_PAGES;
						exh_q       <= 1'b1;
					end
				end else begin
					out_valid_q <= 1'b1;
					if (!owned) begin
						out_stat_q <= pfsa_pkg::STAT_FREE_IGNORE;
					end else if (stack_full) begin
						out_stat_q <= pfsa_pkg::STAT_STACK_FULL;
					end else begin
						out_stat_q  <= pfsa_pkg::STAT_OK;
						stack_cnt_q <= stack_cnt_q + CNT_W'(1);
					end
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_stat_q, out_addr_q};

endmodule

/* rtl/core/page_free_stack_allocator_unit.sv */
// page_free_stack_allocator_unit: top level of the page free stack allocator.
// Depends on pfsa_pkg, pfsa_ctrl and pfsa_datapath.
//
// Hands out pages of PAGE_BYTES bytes from a region set by region_base
// (register 0, rounded down to a page) and region_page_count (register 1,
// limited to MAX_PAGES and to the pages below 4 GiB). Writing either register
// restarts the allocator: free stack emptied, linear cursor back to page 0.
// An allocate (s_tuser 0) with a page-multiple length returns the most
// recently freed page, else the next never-used page, else status 2; a free
// (s_tuser 1) of an aligned page address inside the region is pushed on the
// free stack unless it is full. One result beat per request beat. An allocate
// served from the free stack passes a pop state, since the stack sits in a
// single-port memory with a registered read. The stack needs no clearing
// pass after reset; requests are taken from the first cycle on.
module page_free_stack_allocator_unit #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] request_length, [63:32] free_address
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] page_address, [34:32] status, rest zero
);

	pfsa_pkg::pfsa_cmd_t  cmd;
	pfsa_pkg::pfsa_stat_t stat;

	pfsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfsa_datapath #(
		.MAX_PAGES  (MAX_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

	// a request is only taken when the result register can hold its answer
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("request taken while result register blocked");

	// every accepted beat either shows a result next cycle or waits on the stack read
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (m_tvalid || !s_tready))
		else $error("accepted request produced no result");

	// a result with a status other than OK carries a zero address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[34:32] != pfsa_pkg::STAT_OK)) |-> (m_tdata[31:0] == 32'd0))
		else $error("failed request returned a page address");

	// status code stays within the defined set
	a_stat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] <= pfsa_pkg::STAT_STACK_FULL))
		else $error("undefined status code");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for page_free_stack_allocator_unit.
// It predicts every grant from its own region/stack/cursor state and checks each result
// beat in order. It depends on pfsa_pkg and the RTL top level only.
module tb_top;

	localparam int MAX_PAGES   = 32768;
	localparam int PAGE_SHIFT  = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 235;

	typedef struct packed {
		logic [31:0]       page_addr;
		pfsa_pkg::status_t st;
	} grant_t;

	typedef enum logic [1:0] {K_ALLOC, K_FREE, K_BASE, K_COUNT} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [31:0] len;    // request length, or register data
		logic [31:0] addr;
		bit          typed;
		grant_t      want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // [31:0] request_length, [63:32] free_address
	logic        s_tuser;   // [0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] page_address, [34:32] status, rest zero

	// predicted allocator state
	logic [31:0] base_r;
	logic [15:0] count_r;
	logic [14:0] page_stack [MAX_PAGES];
	int unsigned stack_depth;
	int unsigned next_page;
	bit          cursor_done;

	grant_t grant_q [$];
	row_t   dir_rows [$];
	int     mismatches = 0;
	int     tx_pct = 0;
	int     rx_pct = 0;
	bit     hold_req = 1'b0;

	page_free_stack_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	function automatic logic [31:0] region_start();
		return {base_r[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
	endfunction

	// count limited by stack depth and by the room left below 4 GiB
	function automatic int unsigned usable_pages();
		longint unsigned room;
		longint unsigned n;
		room = (64'h1_0000_0000 - region_start()) >> PAGE_SHIFT;
		n = count_r;
		if (n > MAX_PAGES)
			n = MAX_PAGES;
		if (n > room)
			n = room;
		return 32'(n);
	endfunction

	function automatic void restart_region();
		stack_depth = 0;
		next_page   = 0;
		cursor_done = (usable_pages() == 0);
	endfunction

	function automatic grant_t predict_grant(logic op, logic [31:0] len, logic [31:0] addr);
		grant_t      g;
		logic [31:0] start;
		logic [31:0] off;
		int unsigned pages;
		start = region_start();
		pages = usable_pages();
		g.page_addr = '0;
		if (op == pfsa_pkg::OP_ALLOC) begin
			if (len[PAGE_SHIFT-1:0] != '0) begin
				g.st = pfsa_pkg::STAT_BAD_LEN;
			end else if (stack_depth > 0) begin
				stack_depth--;
				g.page_addr = start + (32'(page_stack[stack_depth]) << PAGE_SHIFT);
				g.st = pfsa_pkg::STAT_OK;
			end else if (!cursor_done && next_page < pages) begin
				g.page_addr = start + (32'(next_page) << PAGE_SHIFT);
				next_page++;
				if (next_page >= pages)
					cursor_done = 1'b1;
				g.st = pfsa_pkg::STAT_OK;
			end else begin
				cursor_done = 1'b1;
				g.st = pfsa_pkg::STAT_NO_PAGES;
			end
		end else begin
			off = addr - start;
			if (addr < start || off[PAGE_SHIFT-1:0] != '0 || (off >> PAGE_SHIFT) >= pages) begin
				g.st = pfsa_pkg::STAT_FREE_IGNORE;
			end else if (stack_depth >= MAX_PAGES) begin
				g.st = pfsa_pkg::STAT_STACK_FULL;
			end else begin
				page_stack[stack_depth] = 15'(off >> PAGE_SHIFT);
				stack_depth++;
				g.st = pfsa_pkg::STAT_OK;
			end
		end
		return g;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// one request beat; cfg_we is dropped here after any register write
	task automatic send_req(input logic op, input logic [31:0] len, input logic [31:0] addr,
			input bit typed, input grant_t want);
		grant_t g;
		cfg_we <= 1'b0;
		while ($urandom_range(0, 99) < tx_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {addr, len};
		do @(posedge clk); while (!s_tready);
		g = predict_grant(op, len, addr);
		grant_q.push_back(typed ? want : g);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (grant_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == pfsa_pkg::REG_REGION_BASE)
			base_r = val;
		else
			count_r = val[15:0];
		restart_region();
	endtask

	task automatic random_region();
		logic [31:0] base;
		logic [31:0] count;
		int unsigned pick;
		base  = $urandom;
		pick  = $urandom_range(0, 9);
		count = $urandom_range(1, 48);
		if (pick == 0)
			base = 32'hFFFF_F000 - ($urandom_range(0, 20) << PAGE_SHIFT);
		if (pick == 1)
			count = '0;
		else if (pick == 2)
			count = $urandom;
		wait_idle();
		write_reg(pfsa_pkg::REG_REGION_BASE, base);
		if (pick != 3)
			write_reg(pfsa_pkg::REG_PAGE_COUNT, count);
	endtask

	// mostly page-multiple allocs and in-region frees, some raw noise
	task automatic random_req();
		logic [31:0] start;
		logic [31:0] len;
		logic [31:0] addr;
		int unsigned pages;
		int unsigned pick;
		start = region_start();
		pages = usable_pages();
		len   = $urandom;
		addr  = $urandom;
		pick  = $urandom_range(0, 99);
		if (pick < 45) begin
			len[PAGE_SHIFT-1:0] = '0;
			if ($urandom_range(0, 9) == 0)
				len = '0;
			send_req(pfsa_pkg::OP_ALLOC, len, addr, 1'b0, '0);
		end else if (pick < 80) begin
			addr = start + ($urandom_range(0, pages) << PAGE_SHIFT);
			send_req(pfsa_pkg::OP_FREE, len, addr, 1'b0, '0);
		end else if (pick < 90) begin
			send_req(pfsa_pkg::OP_ALLOC, len, addr, 1'b0, '0);
		end else begin
			send_req(pfsa_pkg::OP_FREE, len, addr, 1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("page_free_stack_allocator_unit verification failed");
		$finish;
	end

	// result side: scoreboard plus ready pattern, long hold-off on request
	initial begin
		int     hold_left;
		grant_t want;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (grant_q.size() == 0) begin
					flag_mismatch($sformatf("result beat %h with no request pending", m_tdata));
				end else begin
					want = grant_q.pop_front();
					if (m_tdata[31:0] !== want.page_addr)
						flag_mismatch($sformatf("page_address %h, expected %h",
							m_tdata[31:0], want.page_addr));
					if (m_tdata[34:32] !== want.st)
						flag_mismatch($sformatf("status %0d, expected %0d",
							m_tdata[34:32], want.st));
					if (m_tdata[39:35] !== '0)
						flag_mismatch($sformatf("pad bits %b not zero", m_tdata[39:35]));
				end
			end
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_pct);
			end
		end
	end

	initial begin
		int guard;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tuser   <= 1'b0;
		s_tdata   <= '0;
		base_r  = 32'h0000_1000;
		count_r = 16'd16;
		restart_region();

		dir_rows = '{
			// reset region: base 0x1000, 16 pages
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_1000, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0FFF, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_BAD_LEN}},
			'{K_ALLOC, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_BAD_LEN}},
			'{K_ALLOC, 32'hFFFF_F000, 32'h0, 1'b1, '{32'h0000_2000, pfsa_pkg::STAT_OK}},
			'{K_FREE,  32'h0, 32'h0000_1000, 1'b1, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_FREE,  32'h0, 32'h0000_1000, 1'b1, '{32'h0, pfsa_pkg::STAT_OK}}, // same page
			'{K_FREE,  32'h0, 32'h0000_1001, 1'b1, '{32'h0, pfsa_pkg::STAT_FREE_IGNORE}},
			'{K_FREE,  32'h0, 32'hFFFF_FFFF, 1'b1, '{32'h0, pfsa_pkg::STAT_FREE_IGNORE}},
			'{K_FREE,  32'h0, 32'h0001_1000, 1'b1, '{32'h0, pfsa_pkg::STAT_FREE_IGNORE}},
			'{K_FREE,  32'h0, 32'h0001_0000, 1'b1, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_1000, 32'h0, 1'b1, '{32'h0001_0000, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_2000, 32'h0, 1'b1, '{32'h0000_1000, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_3000, 32'h0, 1'b1, '{32'h0000_1000, pfsa_pkg::STAT_OK}},
			// zero base, two pages
			'{K_BASE,  32'h0000_0000, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_COUNT, 32'h0000_0002, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_1000, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_NO_PAGES}},
			'{K_FREE,  32'h0, 32'h0000_0000, 1'b1, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_OK}},
			// misaligned base at the top: one page fits below 4 GiB
			'{K_BASE,  32'hFFFF_FFFF, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'hFFFF_F000, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_NO_PAGES}},
			'{K_FREE,  32'h0, 32'hFFFF_FFFF, 1'b1, '{32'h0, pfsa_pkg::STAT_FREE_IGNORE}},
			'{K_FREE,  32'h0, 32'hFFFF_F000, 1'b1, '{32'h0, pfsa_pkg::STAT_OK}},
			// empty region
			'{K_COUNT, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, pfsa_pkg::STAT_NO_PAGES}},
			'{K_FREE,  32'h0, 32'hFFFF_F000, 1'b1, '{32'h0, pfsa_pkg::STAT_FREE_IGNORE}},
			// count far beyond what the stack and address space allow
			'{K_COUNT, 32'hFFFF_FFFF, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b1, '{32'hFFFF_F000, pfsa_pkg::STAT_OK}},
			'{K_BASE,  32'h1234_5ABC, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_ALLOC, 32'h0000_0000, 32'h0, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_FREE,  32'h0, 32'h1234_5ABC, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}},
			'{K_FREE,  32'h0, 32'h1A34_4000, 1'b0, '{32'h0, pfsa_pkg::STAT_OK}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_pct = 12;
		rx_pct = 12;
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				K_ALLOC: send_req(pfsa_pkg::OP_ALLOC, dir_rows[i].len, $urandom,
					dir_rows[i].typed, dir_rows[i].want);
				K_FREE: send_req(pfsa_pkg::OP_FREE, $urandom, dir_rows[i].addr,
					dir_rows[i].typed, dir_rows[i].want);
				K_BASE: begin
					wait_idle();
					write_reg(pfsa_pkg::REG_REGION_BASE, dir_rows[i].len);
				end
				K_COUNT: begin
					wait_idle();
					write_reg(pfsa_pkg::REG_PAGE_COUNT, dir_rows[i].len);
				end
				default: begin
				end
			endcase
		end

		// frees at and just past the region start, then a mixed burst
		tx_pct = 0;
		rx_pct = 0;
		send_req(pfsa_pkg::OP_FREE, $urandom, region_start(), 1'b0, '0);
		send_req(pfsa_pkg::OP_FREE, $urandom, region_start() + 32'h10, 1'b0, '0);
		repeat (40)
			random_req();

		for (int p = 0; p < N_PHASES; p++) begin
			random_region();
			case (p % 4)
				0: begin
					tx_pct = 0;
					rx_pct = 0;
				end
				1: begin
					tx_pct = 56;
					rx_pct = 0;
				end
				2: begin
					tx_pct = 0;
					rx_pct = 56;
				end
				default: begin
					tx_pct = 12;
					rx_pct = 12;
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 100)
					hold_req = 1'b1;
				if (p == 2 && i == 120)
					wait_idle();
				random_req();
			end
		end

		s_tvalid <= 1'b0;
		rx_pct = 0;
		guard = 0;
		while (grant_q.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (16) @(posedge clk);
		if (grant_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", grant_q.size()));

		if (mismatches == 0)
			$display("page_free_stack_allocator_unit verification clean");
		else
			$display("page_free_stack_allocator_unit verification failed");
		$finish;
	end

endmodule
